// ===== design/acrd_pkg.sv =====
// Shared constants and transfer types for the Aztec center-run detector.
package acrd_pkg;

	localparam int RUN_BITS    = 12;
	localparam int POS_BITS    = RUN_BITS + 1;
	localparam int WINDOW_RUNS = 7;
	localparam int COUNT_BITS  = 4;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [POS_BITS-1:0]   POS_MAX   = '1;
	localparam logic [RUN_BITS-1:0]   RUN_MAX   = '1;

	typedef struct packed {
		logic [RUN_BITS-1:0] run_length;
		logic                row_start;
	} acrd_run_t;

	typedef struct packed {
		logic                hit;
		logic [POS_BITS-1:0] center_x2;
		logic [RUN_BITS-1:0] window_width;
	} acrd_res_t;

	// Stage-one status handed from the run window to the top level.
	typedef struct packed {
		logic valid;
		logic test;
	} acrd_ctl_t;

endpackage

// ===== design/acrd_run_window.sv =====
// Run history shift line, row position and stage-one register of the detector.
module acrd_run_window #(
	parameter int WINDOW_RUNS = acrd_pkg::WINDOW_RUNS,
	localparam int HIST_DEPTH = WINDOW_RUNS + 2,
	localparam int LINE_DEPTH = HIST_DEPTH + 1
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            take,
	input  logic                                            drain,
	input  acrd_pkg::acrd_run_t                             run,
	output acrd_pkg::acrd_ctl_t                             ctl,
	output logic [HIST_DEPTH-1:0][acrd_pkg::RUN_BITS-1:0]   hist,
	output logic [acrd_pkg::POS_BITS-1:0]                   lead_pixels
);

	logic [LINE_DEPTH-1:0][acrd_pkg::RUN_BITS-1:0] line_q;
	logic [LINE_DEPTH-1:0][acrd_pkg::RUN_BITS-1:0] line_next;
	logic [acrd_pkg::POS_BITS-1:0]                 pbo_q;
	logic [acrd_pkg::COUNT_BITS-1:0]               count_q;
	logic                                          parity_q;
	logic                                          valid_s1;
	logic                                          test_s1;

	logic [acrd_pkg::POS_BITS-1:0]   pre_pbo;
	logic [acrd_pkg::COUNT_BITS-1:0] pre_count;
	logic                            pre_parity;
	logic [acrd_pkg::POS_BITS:0]     pbo_sum;
	logic [acrd_pkg::POS_BITS-1:0]   pbo_next;
	logic [acrd_pkg::COUNT_BITS-1:0] count_next;
	logic                            test_next;

	// A row start acts on the state before this run is taken in.
	always_comb begin
		pre_pbo    = run.row_start ? '0 : pbo_q;
		pre_count  = run.row_start ? '0 : count_q;
		pre_parity = run.row_start ? 1'b0 : parity_q;
		for (int i = 0; i < HIST_DEPTH; i++) begin
			line_next[i] = run.row_start ? '0 : line_q[i+1];
		end
		line_next[LINE_DEPTH-1] = run.run_length;
	end

	assign pbo_sum    = {1'b0, pre_pbo} + (acrd_pkg::POS_BITS + 1)'(line_next[0]);
	assign pbo_next   = pbo_sum[acrd_pkg::POS_BITS] ? acrd_pkg::POS_MAX
		: pbo_sum[acrd_pkg::POS_BITS-1:0];
	assign count_next = (pre_count == acrd_pkg::COUNT_MAX) ? pre_count
		: pre_count + acrd_pkg::COUNT_BITS'(1);
	assign test_next  = pre_parity && (pre_count >= acrd_pkg::COUNT_BITS'(HIST_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q   <= '0;
			pbo_q    <= '0;
			count_q  <= '0;
			parity_q <= 1'b0;
			valid_s1 <= 1'b0;
			test_s1  <= 1'b0;
		end else begin
			if (take) begin
				line_q   <= line_next;
				pbo_q    <= pbo_next;
				count_q  <= count_next;
				parity_q <= ~pre_parity;
				valid_s1 <= 1'b1;
				test_s1  <= test_next;
			end else if (drain) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// The oldest line entries are the history as it stood when the run arrived.
	assign hist        = line_q[HIST_DEPTH-1:0];
	assign lead_pixels = pbo_q;
	assign ctl.valid   = valid_s1;
	assign ctl.test    = test_s1;

endmodule

// ===== design/acrd_match_eval.sv =====
// Center-window match test and result fields for one stage-one item.
module acrd_match_eval #(
	parameter int WINDOW_RUNS = acrd_pkg::WINDOW_RUNS,
	localparam int HIST_DEPTH = WINDOW_RUNS + 2
) (
	input  logic [HIST_DEPTH-1:0][acrd_pkg::RUN_BITS-1:0] hist,
	input  logic [acrd_pkg::POS_BITS-1:0]                 lead_pixels,
	input  logic                                          test,
	output acrd_pkg::acrd_res_t                           res
);

	localparam int PAIRS    = WINDOW_RUNS - 1;
	localparam int MID      = WINDOW_RUNS / 2;
	localparam int PAIR_W   = acrd_pkg::RUN_BITS + 1;
	localparam int SCALE_W  = acrd_pkg::RUN_BITS + 3;
	localparam int SUM_W    = acrd_pkg::RUN_BITS + $clog2(WINDOW_RUNS + 1);
	localparam int POSSUM_W = acrd_pkg::POS_BITS + $clog2(MID + 1);
	localparam int CX_W     = POSSUM_W + 1;

	logic [PAIR_W-1:0]   pair_sum [PAIRS];
	logic [PAIR_W-1:0]   lo;
	logic [PAIR_W-1:0]   hi;
	logic [SCALE_W-1:0]  hi_x3;
	logic [SCALE_W-1:0]  lo_x4p3;
	logic [PAIR_W-1:0]   mid_run;
	logic                ratio_ok;
	logic                lead_ok;
	logic                trail_ok;
	logic                match;
	logic [POSSUM_W-1:0] pos;
	logic [CX_W-1:0]     cx2;
	logic [SUM_W-1:0]    width_sum;

	always_comb begin
		for (int i = 0; i < PAIRS; i++) begin
			pair_sum[i] = PAIR_W'(hist[i+1]) + PAIR_W'(hist[i+2]);
		end
		lo = pair_sum[0];
		hi = pair_sum[0];
		for (int i = 1; i < PAIRS; i++) begin
			if (pair_sum[i] < lo) lo = pair_sum[i];
			if (pair_sum[i] > hi) hi = pair_sum[i];
		end
	end

	// hi <= floor(4*lo/3) + 1 holds exactly when 3*hi <= 4*lo + 3.
	assign hi_x3    = (SCALE_W'(hi) << 1) + SCALE_W'(hi);
	assign lo_x4p3  = (SCALE_W'(lo) << 2) + SCALE_W'(3);
	assign ratio_ok = (hi_x3 <= lo_x4p3);

	assign mid_run  = PAIR_W'(hist[MID+1]);
	assign lead_ok  = mid_run <= PAIR_W'(hist[0]) + PAIR_W'(2);
	assign trail_ok = mid_run <= PAIR_W'(hist[HIST_DEPTH-1]) + PAIR_W'(2);
	assign match    = test && ratio_ok && lead_ok && trail_ok;

	always_comb begin
		pos       = POSSUM_W'(lead_pixels);
		width_sum = '0;
		for (int i = 1; i <= MID; i++) begin
			pos = pos + POSSUM_W'(hist[i]);
		end
		for (int i = 1; i <= WINDOW_RUNS; i++) begin
			width_sum = width_sum + SUM_W'(hist[i]);
		end
	end

	assign cx2 = {pos, 1'b0} + CX_W'(hist[MID+1]);

	always_comb begin
		res.hit          = match;
		res.center_x2    = '0;
		res.window_width = '0;
		if (match) begin
			res.center_x2 = (cx2 > CX_W'(acrd_pkg::POS_MAX)) ? acrd_pkg::POS_MAX
				: cx2[acrd_pkg::POS_BITS-1:0];
			res.window_width = (width_sum > SUM_W'(acrd_pkg::RUN_MAX)) ? acrd_pkg::RUN_MAX
				: width_sum[acrd_pkg::RUN_BITS-1:0];
		end
	end

endmodule

// ===== design/aztec_center_run_detector.sv =====
// Top level of the Aztec center-run detector: handshakes, result register, checks.
// Path: an accepted run passes through the stage-one register and then the result register.
// Throughput: one run per cycle while the result side does not stall; the stage-one
//   register and the result register form a two-deep path, so one stalled result
//   still lets one more run enter before run_stall rises.
// Reset (arst_n low, asynchronous): history, run count, parity and position clear,
//   both stages empty; the first run after reset is treated as the start of a row.
module aztec_center_run_detector #(
	parameter int WINDOW_RUNS = acrd_pkg::WINDOW_RUNS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                run_valid,
	output logic                run_stall,
	input  acrd_pkg::acrd_run_t run_item,
	output logic                res_valid,
	input  logic                res_stall,
	output acrd_pkg::acrd_res_t res_item
);

	localparam int HIST_DEPTH = WINDOW_RUNS + 2;

	acrd_pkg::acrd_ctl_t                           ctl;
	logic [HIST_DEPTH-1:0][acrd_pkg::RUN_BITS-1:0] hist;
	logic [acrd_pkg::POS_BITS-1:0]                 lead_pixels;
	acrd_pkg::acrd_res_t                           eval_res;

	logic                res_valid_q;
	acrd_pkg::acrd_res_t res_item_q;
	logic                res_free;
	logic                move;
	logic                run_take;

	// The result register can load when empty or when its transfer completes now.
	assign res_free  = !res_valid_q || !res_stall;
	// Advance stage one into the result register.
	assign move      = ctl.valid && res_free;
	// Hold the input only when stage one is full and cannot drain.
	assign run_stall = ctl.valid && !res_free;
	assign run_take  = run_valid && !run_stall;

	// Shift the run into the history and register the window state.
	acrd_run_window #(
		.WINDOW_RUNS(WINDOW_RUNS)
	) u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (run_take),
		.drain      (move),
		.run        (run_item),
		.ctl        (ctl),
		.hist       (hist),
		.lead_pixels(lead_pixels)
	);

	// Test the window that ended two runs back and build the result fields.
	acrd_match_eval #(
		.WINDOW_RUNS(WINDOW_RUNS)
	) u_eval (
		.hist       (hist),
		.lead_pixels(lead_pixels),
		.test       (ctl.test),
		.res        (eval_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			if (move) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				// Drop the result once its transfer completes.
				res_valid_q <= 1'b0;
			end
		end
	end

	// Result payload needs no reset; it is qualified by res_valid_q.
	always_ff @(posedge clk) begin
		if (move) begin
			res_item_q <= eval_res;
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_item_q;

	// A result without a hit carries zero fields.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_item_q.hit |-> res_item_q.center_x2 == '0
			&& res_item_q.window_width == '0)
		else $error("miss result with nonzero fields");

	// A run that starts a row never triggers a window test.
	a_row_start_no_test: assert property (@(posedge clk) disable iff (!arst_n)
		run_take && run_item.row_start |=> !ctl.test)
		else $error("window test armed on row start");

	// The input side stalls only while stage one is occupied and blocked.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		run_stall |-> ctl.valid && res_valid_q && res_stall)
		else $error("input stalled without a blocked result");

	// An item that leaves stage one shows up in the result register.
	a_move_lands: assert property (@(posedge clk) disable iff (!arst_n)
		move |=> res_valid_q)
		else $error("stage-one item lost on the way to the result register");

endmodule
